// ----- src/caf_pkg.sv -----
// Shared types and constants for the CPU ALU with flags.
package caf_pkg;

  // Operation codes
  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_ADC       = 4'd1,
    OP_SUB       = 4'd2,
    OP_SBC       = 4'd3,
    OP_XOR       = 4'd4,
    OP_INC8      = 4'd5,
    OP_DEC8      = 4'd6,
    OP_INC16     = 4'd7,
    OP_DEC16     = 4'd8,
    OP_ADD16     = 4'd9,
    OP_ADDSP     = 4'd10,
    OP_LOADFLAGS = 4'd11
  } op_e;

  // Branch condition codes
  typedef enum logic [2:0] {
    COND_ALWAYS = 3'd0,
    COND_C      = 3'd1,
    COND_NC     = 3'd2,
    COND_Z      = 3'd3,
    COND_NZ     = 3'd4
  } cond_e;

  // Flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned FLAGS_W = 4;

  typedef logic [FLAGS_W-1:0] flags_t;
  typedef logic [DATA_W-1:0]  word_t;

endpackage

// ----- src/cpu_alu_with_flags_core.sv -----
// Top level of the CPU ALU with flags: input register, ALU and result register.
//
// Executes one SM83-style ALU operation per transfer and keeps the Z/N/H/C flag
// register. Each item passes through an input register and a result register, so
// a result is presented from the result register once its item has left the input
// register; with no output stall the block takes one item every cycle. The
// flag register is updated when an item
// moves from the input register into the result register, which keeps the flag
// dependency between consecutive items within the combinational ALU logic. The
// condition output is evaluated on the flags as they stood before the item's own
// update. Unused operation codes return zero and keep the flags; unused
// condition codes report the condition as not met.
module cpu_alu_with_flags_core
  import caf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  operation_i,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  input  logic [2:0]  condition_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_o,
  output logic [3:0]  flags_out_o,
  output logic        cond_met_o
);

  // Input register
  logic        s1_valid_q;
  logic [3:0]  op_q;
  word_t       a_q;
  word_t       b_q;
  logic [2:0]  cond_q;

  // Flag state and result register
  flags_t      flags_q;
  flags_t      flags_d;
  logic        out_valid_q;
  word_t       res_q;
  word_t       res_d;
  flags_t      out_flags_q;
  logic        met_q;
  logic        met_d;

  // Handshake
  logic        out_ready;
  logic        s1_adv;
  logic        in_xfer;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Hold the input item until the ALU stage can advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= operation_i;
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
      cond_q <= condition_i;
    end
  end

  // ALU datapath
  logic [7:0] a8;
  logic [7:0] b8;
  logic       cin;
  logic       c_sel;
  logic [8:0] sum9;
  logic [4:0] sum5;
  logic [8:0] diff9;
  logic [4:0] diff5;
  logic [7:0] inc8;
  logic [7:0] dec8;
  logic [16:0] sum17;
  logic [12:0] sum13;
  word_t      sp_sum;

  always_comb begin
    a8    = a_q[7:0];
    b8    = b_q[7:0];
    cin   = flags_q[FLAG_C];
    c_sel = ((op_e'(op_q) == OP_ADC) || (op_e'(op_q) == OP_SBC)) ? cin : 1'b0;

    sum9   = {1'b0, a8} + {1'b0, b8} + {8'd0, c_sel};
    sum5   = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, c_sel};
    diff9  = {1'b0, a8} - {1'b0, b8} - {8'd0, c_sel};
    diff5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, c_sel};
    inc8   = a8 + 8'd1;
    dec8   = a8 - 8'd1;
    sum17  = {1'b0, a_q} + {1'b0, b_q};
    sum13  = {1'b0, a_q[11:0]} + {1'b0, b_q[11:0]};
    sp_sum = a_q + {{8{b8[7]}}, b8};

    // Condition on the flags before this update
    case (cond_e'(cond_q))
      COND_ALWAYS: met_d = 1'b1;
      COND_C:      met_d = flags_q[FLAG_C];
      COND_NC:     met_d = !flags_q[FLAG_C];
      COND_Z:      met_d = flags_q[FLAG_Z];
      COND_NZ:     met_d = !flags_q[FLAG_Z];
      default:     met_d = 1'b0;
    endcase

    res_d   = '0;
    flags_d = flags_q;
    case (op_e'(op_q))
      OP_ADD, OP_ADC: begin
        res_d           = {8'd0, sum9[7:0]};
        flags_d[FLAG_Z] = (sum9[7:0] == 8'd0);
        flags_d[FLAG_N] = 1'b0;
        flags_d[FLAG_H] = sum5[4];
        flags_d[FLAG_C] = sum9[8];
      end
      OP_SUB, OP_SBC: begin
        res_d           = {8'd0, diff9[7:0]};
        flags_d[FLAG_Z] = (diff9[7:0] == 8'd0);
        flags_d[FLAG_N] = 1'b1;
        flags_d[FLAG_H] = diff5[4];
        flags_d[FLAG_C] = diff9[8];
      end
      OP_XOR: begin
        res_d           = {8'd0, a8 ^ b8};
        flags_d[FLAG_Z] = ((a8 ^ b8) == 8'd0);
        flags_d[FLAG_N] = 1'b0;
        flags_d[FLAG_H] = 1'b0;
        flags_d[FLAG_C] = 1'b0;
      end
      OP_INC8: begin
        res_d           = {8'd0, inc8};
        flags_d[FLAG_Z] = (inc8 == 8'd0);
        flags_d[FLAG_N] = 1'b0;
        flags_d[FLAG_H] = (inc8[3:0] == 4'h0);
      end
      OP_DEC8: begin
        res_d           = {8'd0, dec8};
        flags_d[FLAG_Z] = (dec8 == 8'd0);
        flags_d[FLAG_N] = 1'b1;
        flags_d[FLAG_H] = (dec8[3:0] == 4'hF);
      end
      OP_INC16: begin
        res_d = a_q + 16'd1;
      end
      OP_DEC16: begin
        res_d = a_q - 16'd1;
      end
      OP_ADD16: begin
        res_d           = sum17[15:0];
        flags_d[FLAG_N] = 1'b0;
        flags_d[FLAG_H] = sum13[12];
        flags_d[FLAG_C] = sum17[16];
      end
      OP_ADDSP: begin
        res_d           = sp_sum;
        flags_d[FLAG_Z] = 1'b0;
        flags_d[FLAG_N] = 1'b0;
        flags_d[FLAG_H] = sum5[4];
        flags_d[FLAG_C] = sum9[8];
      end
      OP_LOADFLAGS: begin
        res_d   = {a_q[15:4], 4'h0};
        flags_d = a_q[7:4];
      end
      default: begin
        res_d   = '0;
        flags_d = flags_q;
      end
    endcase
  end

  // Advance the flag register with each ALU transfer and the result valid whenever the output is ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        flags_q <= flags_d;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q       <= res_d;
      out_flags_q <= flags_d;
      met_q       <= met_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
  assign flags_out_o = out_flags_q;
  assign cond_met_o  = met_q;

  // Flags change only when an item leaves the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(flags_q))
    else $error("flag register changed without an ALU transfer");

  // A pending result always reports the current flag state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_flags_q == flags_q))
    else $error("result flags differ from flag register");

  // Input is stalled only with an item held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with no backlog");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the CPU ALU with flags: directed table, then random ALU traffic.
`timescale 1ns / 100ps

module tb_top;
  import caf_pkg::*;

  // Opcodes and condition codes outside the defined sets
  localparam logic [3:0] OP_UNUSED_LO    = 4'd12;
  localparam logic [3:0] OP_UNUSED_HI    = 4'd15;
  localparam logic [2:0] COND_UNUSED_LO  = 3'd5;
  localparam logic [2:0] COND_UNUSED_MID = 3'd6;
  localparam logic [2:0] COND_UNUSED_HI  = 3'd7;

  localparam int RESET_CYCLES  = 12;
  localparam int RAND_ITEMS    = 1700;
  localparam int TAIL_CYCLES   = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RX_HOLD       = 64;
  localparam int RX_QUIET_LO   = 400;
  localparam int RX_QUIET_HI   = 900;
  localparam int IDLE_PCT      = 9;

  typedef struct packed {
    word_t  res;
    flags_t flg;
    logic   met;
  } alu_out_t;

  typedef struct packed {
    logic [3:0] op;
    word_t      a;
    word_t      b;
    logic [2:0] cnd;
    logic       typed;
    word_t      res;
    flags_t     flg;
    logic       met;
  } dir_row_t;

  // Directed rows; flags evolve from the all-zero reset state row by row
  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    '{OP_LOADFLAGS, 16'h0000, 16'h0000, COND_ALWAYS,     1'b1, 16'h0000, 4'h0, 1'b1},
    '{OP_ADD,       16'h00FF, 16'h0001, COND_C,          1'b1, 16'h0000, 4'hB, 1'b0},
    '{OP_ADC,       16'hFFFF, 16'hFFFF, COND_C,          1'b1, 16'h00FF, 4'h3, 1'b1},
    '{OP_SUB,       16'h0000, 16'h0001, COND_NC,         1'b1, 16'h00FF, 4'h7, 1'b0},
    '{OP_SBC,       16'h1200, 16'h34FF, COND_Z,          1'b1, 16'h0000, 4'hF, 1'b0},
    '{OP_SBC,       16'h0010, 16'h000F, COND_NZ,         1'b1, 16'h0000, 4'hE, 1'b0},
    '{OP_XOR,       16'h5555, 16'hAAAA, COND_ALWAYS,     1'b1, 16'h00FF, 4'h0, 1'b1},
    '{OP_XOR,       16'h00FF, 16'hFFFF, COND_Z,          1'b1, 16'h0000, 4'h8, 1'b0},
    '{OP_INC8,      16'hFFFF, 16'h0000, COND_NZ,         1'b1, 16'h0000, 4'hA, 1'b0},
    '{OP_DEC8,      16'h0000, 16'hFFFF, COND_UNUSED_LO,  1'b1, 16'h00FF, 4'h6, 1'b0},
    '{OP_INC16,     16'hFFFF, 16'h1234, COND_UNUSED_HI,  1'b1, 16'h0000, 4'h6, 1'b0},
    '{OP_DEC16,     16'h0000, 16'h0000, COND_NC,         1'b1, 16'hFFFF, 4'h6, 1'b1},
    '{OP_ADD16,     16'hFFFF, 16'h0001, COND_ALWAYS,     1'b1, 16'h0000, 4'h3, 1'b1},
    '{OP_ADD16,     16'h0800, 16'h0800, COND_C,          1'b0, 16'h0000, 4'h0, 1'b0},
    '{OP_ADDSP,     16'h0000, 16'h00FF, COND_C,          1'b1, 16'hFFFF, 4'h0, 1'b0},
    '{OP_ADDSP,     16'hFFFF, 16'hFF01, COND_NC,         1'b1, 16'h0000, 4'h3, 1'b1},
    '{OP_ADDSP,     16'h1234, 16'h0080, COND_Z,          1'b0, 16'h0000, 4'h0, 1'b0},
    '{OP_LOADFLAGS, 16'hFFFF, 16'h0000, COND_ALWAYS,     1'b1, 16'hFFF0, 4'hF, 1'b1},
    '{OP_UNUSED_LO, 16'h1234, 16'h0005, COND_Z,          1'b1, 16'h0000, 4'hF, 1'b1},
    '{OP_UNUSED_HI, 16'hFFFF, 16'hFFFF, COND_NZ,         1'b1, 16'h0000, 4'hF, 1'b0},
    '{OP_LOADFLAGS, 16'h0050, 16'h0000, COND_UNUSED_MID, 1'b1, 16'h0050, 4'h5, 1'b0},
    '{OP_ADC,       16'h000F, 16'h0000, COND_C,          1'b1, 16'h0010, 4'h2, 1'b1},
    '{OP_SUB,       16'h0080, 16'h0080, COND_ALWAYS,     1'b0, 16'h0000, 4'h0, 1'b0},
    '{OP_DEC8,      16'h0010, 16'h0000, COND_NZ,         1'b0, 16'h0000, 4'h0, 1'b0},
    '{OP_INC8,      16'h000F, 16'h0000, COND_NC,         1'b0, 16'h0000, 4'h0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  operation = '0;
  word_t       operand_a = '0;
  word_t       operand_b = '0;
  logic [2:0]  condition = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  word_t       result;
  flags_t      flags_out;
  logic        cond_met;

  // Expected-result side channel, driven alongside each payload
  logic        drv_typed = 1'b0;
  alu_out_t    drv_exp = '0;

  logic        hold_req = 1'b0;
  bit          tx_quiet = 1'b0;
  int          errors = 0;
  int          cycles = 0;
  flags_t      flags_now = '0;
  alu_out_t    queued_alu_results[$];

  cpu_alu_with_flags_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .operation_i (operation),
    .operand_a_i (operand_a),
    .operand_b_i (operand_b),
    .condition_i (condition),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .result_o    (result),
    .flags_out_o (flags_out),
    .cond_met_o  (cond_met)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Compute one ALU step: result, updated flags and condition on the old flags
  function automatic alu_out_t alu_compute(logic [3:0] op, word_t a, word_t b,
                                           logic [2:0] cnd, flags_t f);
    alu_out_t   r;
    logic [7:0] a8;
    logic [7:0] b8;
    logic [7:0] r8;
    logic       cy;
    logic [4:0] s5;
    logic [8:0] s9;
    logic [12:0] s13;
    logic [16:0] s17;
    a8    = a[7:0];
    b8    = b[7:0];
    r.res = '0;
    r.flg = f;
    case (cnd)
      COND_ALWAYS: r.met = 1'b1;
      COND_C:      r.met = f[FLAG_C];
      COND_NC:     r.met = !f[FLAG_C];
      COND_Z:      r.met = f[FLAG_Z];
      COND_NZ:     r.met = !f[FLAG_Z];
      default:     r.met = 1'b0;
    endcase
    case (op)
      OP_ADD, OP_ADC: begin
        cy  = (op == OP_ADC) ? f[FLAG_C] : 1'b0;
        s9  = {1'b0, a8} + {1'b0, b8} + {8'd0, cy};
        s5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cy};
        r.res = {8'h00, s9[7:0]};
        r.flg[FLAG_Z] = (s9[7:0] == 8'h00);
        r.flg[FLAG_N] = 1'b0;
        r.flg[FLAG_H] = s5[4];
        r.flg[FLAG_C] = s9[8];
      end
      OP_SUB, OP_SBC: begin
        // Sign bit of the widened difference is the true borrow
        cy  = (op == OP_SBC) ? f[FLAG_C] : 1'b0;
        s9  = {1'b0, a8} - {1'b0, b8} - {8'd0, cy};
        s5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cy};
        r.res = {8'h00, s9[7:0]};
        r.flg[FLAG_Z] = (s9[7:0] == 8'h00);
        r.flg[FLAG_N] = 1'b1;
        r.flg[FLAG_H] = s5[4];
        r.flg[FLAG_C] = s9[8];
      end
      OP_XOR: begin
        r8 = a8 ^ b8;
        r.res = {8'h00, r8};
        r.flg = '0;
        r.flg[FLAG_Z] = (r8 == 8'h00);
      end
      OP_INC8, OP_DEC8: begin
        r8 = (op == OP_INC8) ? a8 + 8'd1 : a8 - 8'd1;
        r.res = {8'h00, r8};
        r.flg[FLAG_Z] = (r8 == 8'h00);
        r.flg[FLAG_N] = (op == OP_DEC8);
        r.flg[FLAG_H] = (op == OP_INC8) ? (r8[3:0] == 4'h0) : (r8[3:0] == 4'hF);
      end
      OP_INC16: r.res = a + 16'd1;
      OP_DEC16: r.res = a - 16'd1;
      OP_ADD16: begin
        s17 = {1'b0, a} + {1'b0, b};
        s13 = {1'b0, a[11:0]} + {1'b0, b[11:0]};
        r.res = s17[15:0];
        r.flg[FLAG_N] = 1'b0;
        r.flg[FLAG_H] = s13[12];
        r.flg[FLAG_C] = s17[16];
      end
      OP_ADDSP: begin
        // Signed offset for the sum, unsigned low-byte carries for H and C
        r.res = a + {{8{b8[7]}}, b8};
        s5  = {1'b0, a[3:0]} + {1'b0, b8[3:0]};
        s9  = {1'b0, a8} + {1'b0, b8};
        r.flg = '0;
        r.flg[FLAG_H] = s5[4];
        r.flg[FLAG_C] = s9[8];
      end
      OP_LOADFLAGS: begin
        r.res = {a[15:4], 4'h0};
        r.flg = a[7:4];
      end
      default: r.res = '0;
    endcase
    return r;
  endfunction

  // Bias operands toward carry and borrow boundaries
  function automatic word_t pick_operand();
    case ($urandom_range(11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h00FF;
      3:       return 16'h0FFF;
      4:       return {8'h00, 4'($urandom_range(15)), 4'hF};
      5:       return {8'($urandom), 8'h00};
      6:       return 16'($urandom_range(16));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one transfer after optional idle cycles; return once it is taken
  task automatic send_alu_op(logic [3:0] op, word_t a, word_t b, logic [2:0] cnd,
                             logic typed, alu_out_t want);
    while (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    operand_a <= a;
    operand_b <= b;
    condition <= cnd;
    drv_typed <= typed;
    drv_exp   <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold until every outstanding result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (queued_alu_results.size() != 0) @(posedge clk);
  endtask

  // Stimulus: reset, directed table, random traffic, drain
  initial begin : stim
    logic [3:0] op;
    logic [2:0] cnd;
    alu_out_t   want;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_ROWS; i++) begin
      want = '{DIR_TAB[i].res, DIR_TAB[i].flg, DIR_TAB[i].met};
      send_alu_op(DIR_TAB[i].op, DIR_TAB[i].a, DIR_TAB[i].b, DIR_TAB[i].cnd,
                  DIR_TAB[i].typed, want);
    end
    wait_drained();
    @(posedge clk);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 300) hold_req <= 1'b1;
      tx_quiet = (i >= 700 && i < 1000);
      if (i == 1100) begin
        wait_drained();
        @(posedge clk);
      end
      if ($urandom_range(99) < 4) op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      else                        op = 4'($urandom_range(OP_LOADFLAGS, OP_ADD));
      if ($urandom_range(99) < 8) cnd = 3'($urandom_range(COND_UNUSED_HI, COND_UNUSED_LO));
      else                        cnd = 3'($urandom_range(COND_NZ, COND_ALWAYS));
      send_alu_op(op, pick_operand(), pick_operand(), cnd, 1'b0, '0);
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, one quiet window
  initial begin : rx_drive
    int  rx_cyc;
    int  hold_left;
    bit  hold_seen;
    rx_cyc    = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = RX_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (rx_cyc >= RX_QUIET_LO && rx_cyc < RX_QUIET_HI) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Check each output transfer, then predict each input transfer
  always @(posedge clk) begin : track
    alu_out_t want;
    alu_out_t nxt;
    if (rst_n && out_valid && !out_stall) begin
      if (queued_alu_results.size() == 0) begin
        $display("%0t: unexpected result: got result %h flags %h cond %b",
                 $time, result, flags_out, cond_met);
        errors++;
      end else begin
        want = queued_alu_results.pop_front();
        if (result !== want.res) begin
          $display("%0t: result mismatch: expected %h, got %h", $time, want.res, result);
          errors++;
        end
        if (flags_out !== want.flg) begin
          $display("%0t: flags mismatch: expected %h, got %h", $time, want.flg, flags_out);
          errors++;
        end
        if (cond_met !== want.met) begin
          $display("%0t: cond_met mismatch: expected %b, got %b", $time, want.met, cond_met);
          errors++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      nxt = alu_compute(operation, operand_a, operand_b, condition, flags_now);
      flags_now = nxt.flg;
      queued_alu_results.push_back(drv_typed ? drv_exp : nxt);
    end
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
